>>> hw/rtl/spdt_pkg.sv
// ----------------------------------------------------------------------------
// Solenoid pulse/duty timer bank package
// Shared field widths, item kind codes, defaults and the input word type.
// ----------------------------------------------------------------------------
`default_nettype none

package spdt_pkg;

  localparam int KIND_W     = 2;
  localparam int CHANNEL_W  = 5;
  localparam int DURATION_W = 8;
  localparam int PATTERN_W  = 8;
  localparam int BANK_W     = 2;
  localparam int BITS_W     = 8;
  localparam int ENABLE_W   = 32;
  localparam int PHASE_W    = 8;

  // Channels per bank and the width of a lane index inside a bank.
  localparam int BANK_LANES = 8;
  localparam int LANE_W     = 3;

  localparam int CHANNELS_DEF   = 32;
  localparam int TIMER_BITS_DEF = 8;

  localparam logic [PHASE_W-1:0] PHASE_RESET = PHASE_W'(1);

  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UPDATE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [CHANNEL_W-1:0]  channel;
    logic [DURATION_W-1:0] duration;
    logic [PATTERN_W-1:0]  duty_pattern;
    logic [BANK_W-1:0]     bank;
    logic [BITS_W-1:0]     base_bits;
  } item_t;

endpackage

`default_nettype wire

>>> hw/rtl/spdt_if.sv
// ----------------------------------------------------------------------------
// Solenoid pulse/duty timer bank channel interfaces
// Valid/ready channels for input words, result words and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface spdt_item_if;
  logic                               valid;
  logic                               ready;
  logic [spdt_pkg::KIND_W-1:0]     kind;
  logic [spdt_pkg::CHANNEL_W-1:0]  channel;
  logic [spdt_pkg::DURATION_W-1:0] duration;
  logic [spdt_pkg::PATTERN_W-1:0]  duty_pattern;
  logic [spdt_pkg::BANK_W-1:0]     bank;
  logic [spdt_pkg::BITS_W-1:0]     base_bits;

  modport source (output valid, kind, channel, duration, duty_pattern, bank, base_bits,
                  input ready);
  modport sink   (input valid, kind, channel, duration, duty_pattern, bank, base_bits,
                  output ready);
endinterface

interface spdt_result_if;
  logic                           valid;
  logic                           ready;
  logic [spdt_pkg::BANK_W-1:0] out_bank;
  logic [spdt_pkg::BITS_W-1:0] out_bits;

  modport source (output valid, out_bank, out_bits, input ready);
  modport sink   (input valid, out_bank, out_bits, output ready);
endinterface

interface spdt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [spdt_pkg::ENABLE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/solenoid_pulse_duty_timer_bank.sv
// ----------------------------------------------------------------------------
// Solenoid pulse/duty timer bank
// Per-channel countdown timers and duty patterns, updated one bank at a time.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one word per transfer. A load word sets one channel's
//   timer and duty pattern. An update word names a bank of eight channels
//   and supplies base output bits; every enabled channel of that bank with a
//   running timer counts down by one and, when its pattern overlaps the
//   one-hot duty phase, sets its bit in the result. An advance word rotates
//   the duty phase left, wrapping back to bit 0. Only update words produce
//   a result word on out_chan.
//   cfg_chan writes the 32-bit flasher enable mask; it is always ready and
//   should be written while no word is in flight.
//   A word accepted on in_chan is registered in the input register, and an
//   update word's result is registered in the result register for out_chan.
//   Throughput is one word per cycle unless an update word is held by a
//   stalled out_chan; all work for a word is done in the input register.
//   When out_chan stalls, the result register holds its word; a following
//   load or advance word still completes, while an update word waits in the
//   input register and in_chan drops ready until the result slot frees.
//   Synchronous reset clears all timers and patterns, the enable mask and
//   both valid flags, and sets the duty phase to one.
// ----------------------------------------------------------------------------
`default_nettype none

module solenoid_pulse_duty_timer_bank #(
  parameter int CHANNELS   = spdt_pkg::CHANNELS_DEF,
  parameter int TIMER_BITS = spdt_pkg::TIMER_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  spdt_item_if.sink    in_chan,
  spdt_result_if.source out_chan,
  spdt_cfg_if.sink     cfg_chan
);

  // Channels are stored as rows of one bank each, so an update touches one row.
  localparam int ROWS  = (CHANNELS + spdt_pkg::BANK_LANES - 1) / spdt_pkg::BANK_LANES;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef logic [TIMER_BITS-1:0]            timer_t;
  typedef logic [spdt_pkg::PATTERN_W-1:0]   pattern_t;

  // Input register.
  logic            in_v_r;
  spdt_pkg::item_t in_r;

  // Result register.
  logic                           out_v_r;
  logic [spdt_pkg::BANK_W-1:0] out_bank_r;
  logic [spdt_pkg::BITS_W-1:0] out_bits_r;

  // Channel state.
  timer_t                         timer_r   [ROWS][spdt_pkg::BANK_LANES];
  pattern_t                       pattern_r [ROWS][spdt_pkg::BANK_LANES];
  logic [spdt_pkg::PHASE_W-1:0]  phase_r;
  logic [spdt_pkg::ENABLE_W-1:0] enable_r;

  logic                           advance;
  logic                           is_load;
  logic                           is_update;
  logic                           is_rotate;
  logic                           load_ok;
  logic [ROW_W-1:0]               load_row;
  logic [spdt_pkg::LANE_W-1:0]   load_lane;
  logic [ROW_W-1:0]               bank_row;
  logic [spdt_pkg::BANK_LANES-1:0] lane_active;
  logic [spdt_pkg::BITS_W-1:0]   bits_nxt;
  logic [spdt_pkg::PHASE_W-1:0]  phase_nxt;
  logic [spdt_pkg::BANK_LANES-1:0] bank_enable;

  assign is_load   = (in_r.kind == spdt_pkg::KIND_LOAD);
  assign is_update = (in_r.kind == spdt_pkg::KIND_UPDATE);
  assign is_rotate = (in_r.kind == spdt_pkg::KIND_ADVANCE);

  // The held word retires unless it is an update facing a full, stalled result slot.
  assign advance = in_v_r && (!is_update || !out_v_r || out_chan.ready);

  assign in_chan.ready  = !in_v_r || advance;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid    = out_v_r;
  assign out_chan.out_bank = out_bank_r;
  assign out_chan.out_bits = out_bits_r;

  // Load addressing: upper channel bits pick the row, lower bits the lane.
  assign load_ok   = (int'(in_r.channel) < CHANNELS);
  assign load_row  = ROW_W'(in_r.channel[spdt_pkg::CHANNEL_W-1:spdt_pkg::LANE_W]);
  assign load_lane = in_r.channel[spdt_pkg::LANE_W-1:0];

  assign bank_row    = ROW_W'(in_r.bank);
  assign bank_enable = enable_r[{in_r.bank, spdt_pkg::LANE_W'(0)} +: spdt_pkg::BANK_LANES];

  // Update: each lane of the bank is handled independently.
  always_comb begin
    bits_nxt = in_r.base_bits;
    for (int i = 0; i < spdt_pkg::BANK_LANES; i++) begin
      lane_active[i] = ((int'(in_r.bank) * spdt_pkg::BANK_LANES + i) < CHANNELS) &&
                       bank_enable[i] && (timer_r[bank_row][i] != '0);
      if (lane_active[i] && ((pattern_r[bank_row][i] & phase_r) != '0)) begin
        bits_nxt[i] = 1'b1;
      end
    end
  end

  // Rotate left; the bit leaving the top wraps to bit 0, which keeps the phase one-hot.
  assign phase_nxt = (phase_r[spdt_pkg::PHASE_W-1]) ? spdt_pkg::PHASE_RESET
                                                    : {phase_r[spdt_pkg::PHASE_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      phase_r  <= spdt_pkg::PHASE_RESET;
      enable_r <= '0;
      for (int r = 0; r < ROWS; r++) begin
        for (int i = 0; i < spdt_pkg::BANK_LANES; i++) begin
          timer_r[r][i]   <= '0;
          pattern_r[r][i] <= '0;
        end
      end
    end else begin
      if (in_chan.ready) begin
        in_v_r <= in_chan.valid;
      end
      if (in_chan.valid && in_chan.ready) begin
        in_r.kind         <= in_chan.kind;
        in_r.channel      <= in_chan.channel;
        in_r.duration     <= in_chan.duration;
        in_r.duty_pattern <= in_chan.duty_pattern;
        in_r.bank         <= in_chan.bank;
        in_r.base_bits    <= in_chan.base_bits;
      end

      if (cfg_chan.valid) begin
        enable_r <= cfg_chan.data;
      end

      if (advance && is_update) begin
        out_v_r    <= 1'b1;
        out_bank_r <= in_r.bank;
        out_bits_r <= bits_nxt;
        for (int i = 0; i < spdt_pkg::BANK_LANES; i++) begin
          if (lane_active[i]) begin
            timer_r[bank_row][i] <= timer_r[bank_row][i] - timer_t'(1);
          end
        end
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end

      if (advance && is_load && load_ok) begin
        timer_r[load_row][load_lane]   <= timer_t'(in_r.duration);
        pattern_r[load_row][load_lane] <= in_r.duty_pattern;
      end

      if (advance && is_rotate) begin
        phase_r <= phase_nxt;
      end
    end
  end

  // The duty phase always has exactly one bit set.
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r))
    else $error("duty phase lost its one-hot form");

  // A retiring update word lands in the result register with its bank.
  a_update_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_update) |=> (out_v_r && out_bank_r == $past(in_r.bank)))
    else $error("update word did not produce its result");

  // Base bits are never dropped from a result.
  a_base_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_update) |=>
      ((out_bits_r & $past(in_r.base_bits)) == $past(in_r.base_bits)))
    else $error("result lost requested base bits");

  // A new result only appears after an update word retires.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_v_r) && $past(rst_n)) |-> $past(advance && is_update))
    else $error("result appeared without an update word");

  // A held word that cannot retire stays in the input register unchanged.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !advance) |=> (in_v_r && in_r == $past(in_r)))
    else $error("stalled input word was disturbed");

endmodule

`default_nettype wire
